>>> hdl/csfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csfa_pkg;

   localparam int STORE_BYTES_DEF = 65536;

   localparam int FUNC_W   = 3;
   localparam int FRAME_W  = 13;
   localparam int LEN_W    = 17;
   localparam int ADDR_W   = 16;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int CANARY_W = 32;
   localparam int CAP_W    = 17;
   localparam int HDR_BYTES = 16;

   localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CORRUPT  = 3'd4;

   localparam logic CSR_CANARY   = 1'b0;
   localparam logic CSR_CAPACITY = 1'b1;

   localparam logic [FRAME_W-1:0] FRAME_LIMIT    = 13'd8191;
   localparam logic [CAP_W-1:0]   CAPACITY_RESET = 17'h10000;

   typedef struct packed {
      logic [BYTE_W-1:0]   read_byte;
      logic [ADDR_W-1:0]   alloc_offset;
      logic [FRAME_W-1:0]  frame_count;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

`default_nettype wire

>>> hdl/canary_frame_stack_allocator.sv
// Frame stack allocator over a byte-wide scratchpad with canary-guarded headers.
// req_ channel: one beat per operation; tuser carries func, tdata the operands.
// rsp_ channel: exactly one result beat per request beat, in request order.
// csr_ port: csr_wen writes csr_wdata to the register picked by csr_index
// (0 canary, 1 capacity); write only while no request is in flight.
// Steps from request beat to result beat, with the receiver ready:
//   allocate, byte write, rejected ops and shallow pop: no further step
//   byte read: one store read, then the result
//   push: sixteen header bytes written one per cycle
//   pop of a deeper frame: sixteen header bytes read, then a check step
// The single-port byte store allows one access per cycle.
// One request is worked at a time; req_tready is high while the sequencer idles.
// The result sits in an output register, so the next request is taken while the
// previous result still waits; a further result holds in the sequencer until
// rsp_tready frees the register.
// Reset clears the frame state, the canary and sets the capacity to 65536.
// Store contents are not cleared and are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module canary_frame_stack_allocator #(
   parameter int STORE_BYTES = csfa_pkg::STORE_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [12:0] frame_number, [29:13] alloc_len, [45:30] byte_address,
   // [53:46] write_byte, [55:54] zero
   input  wire logic [55:0] req_tdata,
   // [2:0] func
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] status, [15:3] frame_count, [31:16] alloc_offset, [39:32] read_byte
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_wen,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int AW = $clog2(STORE_BYTES);

   logic [csfa_pkg::CANARY_W-1:0] canary_ff;
   logic [csfa_pkg::CAP_W-1:0]    capacity_ff;
   logic                          rsp_valid_ff;
   logic [39:0]                   rsp_data_ff;

   logic                          res_valid;
   logic                          res_ready;
   csfa_pkg::result_type          res;
   logic                          mem_wen;
   logic                          mem_ren;
   logic [AW-1:0]                 mem_addr;
   logic [csfa_pkg::BYTE_W-1:0]   mem_wdata;
   logic [csfa_pkg::BYTE_W-1:0]   mem_rdata;

   assign res_ready = !rsp_valid_ff || rsp_tready;

   csfa_ctrl #(
      .STORE_BYTES (STORE_BYTES),
      .AW          (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_func  (req_tuser),
      .req_fnum  (req_tdata[12:0]),
      .req_len   (req_tdata[29:13]),
      .req_addr  (req_tdata[45:30]),
      .req_wbyte (req_tdata[53:46]),
      .canary    (canary_ff),
      .capacity  (capacity_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_wen   (mem_wen),
      .mem_ren   (mem_ren),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   csfa_store #(
      .STORE_BYTES (STORE_BYTES),
      .AW          (AW)
   ) u_store (
      .clock (clock),
      .wen   (mem_wen),
      .ren   (mem_ren),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         canary_ff   <= '0;
         capacity_ff <= csfa_pkg::CAPACITY_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            csfa_pkg::CSR_CANARY:   canary_ff   <= csr_wdata;
            csfa_pkg::CSR_CAPACITY: capacity_ff <= csr_wdata[csfa_pkg::CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid && !req_tready)
      else $error("pending result dropped before output register freed");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ready |=> rsp_tvalid)
      else $error("finished result not presented");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= csfa_pkg::STATUS_CORRUPT)
      else $error("undefined status code");

endmodule

`default_nettype wire

>>> hdl/csfa_store.sv
`timescale 1ns / 1ps
`default_nettype none

module csfa_store #(
   parameter int STORE_BYTES = csfa_pkg::STORE_BYTES_DEF,
   parameter int AW          = $clog2(STORE_BYTES)
) (
   input  wire logic                       clock,
   input  wire logic                       wen,
   input  wire logic                       ren,
   input  wire logic [AW-1:0]              addr,
   input  wire logic [csfa_pkg::BYTE_W-1:0] wdata,
   output logic      [csfa_pkg::BYTE_W-1:0] rdata
);

   logic [csfa_pkg::BYTE_W-1:0] store_mem [STORE_BYTES];
   logic [csfa_pkg::BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         store_mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ren) begin
         rdata_ff <= store_mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hdl/csfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module csfa_ctrl #(
   parameter int STORE_BYTES = csfa_pkg::STORE_BYTES_DEF,
   parameter int AW          = $clog2(STORE_BYTES)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [csfa_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [csfa_pkg::FRAME_W-1:0]  req_fnum,
   input  wire logic [csfa_pkg::LEN_W-1:0]    req_len,
   input  wire logic [csfa_pkg::ADDR_W-1:0]   req_addr,
   input  wire logic [csfa_pkg::BYTE_W-1:0]   req_wbyte,
   input  wire logic [csfa_pkg::CANARY_W-1:0] canary,
   input  wire logic [csfa_pkg::CAP_W-1:0]    capacity,
   output logic                               res_valid,
   input  wire logic                          res_ready,
   output csfa_pkg::result_type               res,
   output logic                               mem_wen,
   output logic                               mem_ren,
   output logic [AW-1:0]                      mem_addr,
   output logic [csfa_pkg::BYTE_W-1:0]        mem_wdata,
   input  wire logic [csfa_pkg::BYTE_W-1:0]   mem_rdata
);

   localparam int W = ((AW > csfa_pkg::LEN_W) ? AW : csfa_pkg::LEN_W) + 1;
   localparam int HDR_W = csfa_pkg::HDR_BYTES * csfa_pkg::BYTE_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PUSH   = 3'd1;
   localparam logic [2:0] S_POPRD  = 3'd2;
   localparam logic [2:0] S_POPCHK = 3'd3;
   localparam logic [2:0] S_RDWAIT = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]                      state_ff, state_in;
   logic [4:0]                      cnt_ff, cnt_in;
   logic [AW-1:0]                   end_ff, end_in;
   logic [AW-1:0]                   link_ff, link_in;
   logic [AW-1:0]                   base_ff, base_in;
   logic [csfa_pkg::FRAME_W-1:0]    open_ff, open_in;
   logic                            active_ff, active_in;
   logic [HDR_W-1:0]                hdr_ff, hdr_in;
   logic [csfa_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [csfa_pkg::ADDR_W-1:0]     offset_ff, offset_in;
   logic [csfa_pkg::BYTE_W-1:0]     rbyte_ff, rbyte_in;

   logic [W-1:0]                    eff_cap;
   logic                            push_full;
   logic                            alloc_full;
   logic [csfa_pkg::HDR_BYTES-1:0][csfa_pkg::BYTE_W-1:0] hdr_word;
   logic [63:0]                     saved_link;
   logic                            canary_bad;

   assign eff_cap = (W'(capacity) > W'(STORE_BYTES)) ? W'(STORE_BYTES) : W'(capacity);
   assign push_full  = (W'(end_ff) + W'(csfa_pkg::HDR_BYTES)) >= eff_cap;
   assign alloc_full = (W'(end_ff) + W'(req_len)) >= eff_cap;
   assign hdr_word   = {canary, 64'(link_ff), canary};
   assign saved_link = hdr_ff[95:32];
   assign canary_bad = (hdr_ff[31:0] != canary) || (hdr_ff[127:96] != canary);

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res.status       = status_ff;
   assign res.frame_count  = open_ff;
   assign res.alloc_offset = offset_ff;
   assign res.read_byte    = rbyte_ff;

   assign mem_addr  = (state_ff == S_IDLE) ? AW'(req_addr) : base_ff + AW'(cnt_ff[3:0]);
   assign mem_wdata = (state_ff == S_IDLE) ? req_wbyte : hdr_word[cnt_ff[3:0]];

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      end_in    = end_ff;
      link_in   = link_ff;
      base_in   = base_ff;
      open_in   = open_ff;
      active_in = active_ff;
      hdr_in    = hdr_ff;
      status_in = status_ff;
      offset_in = offset_ff;
      rbyte_in  = rbyte_ff;
      mem_wen   = 1'b0;
      mem_ren   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in  = S_DONE;
               cnt_in    = '0;
               status_in = csfa_pkg::STATUS_OK;
               offset_in = '0;
               rbyte_in  = '0;
               unique case (req_func)
                  csfa_pkg::FUNC_PUSH: begin
                     if (push_full || (open_ff >= csfa_pkg::FRAME_LIMIT)) begin
                        status_in = csfa_pkg::STATUS_NO_SPACE;
                     end else begin
                        base_in  = end_ff;
                        state_in = S_PUSH;
                     end
                  end
                  csfa_pkg::FUNC_POP: begin
                     if (!active_ff || (open_ff == '0)) begin
                        status_in = csfa_pkg::STATUS_EMPTY;
                     end else if (req_fnum != open_ff) begin
                        status_in = csfa_pkg::STATUS_MISMATCH;
                     end else if (open_ff == csfa_pkg::FRAME_W'(1)) begin
                        end_in    = '0;
                        link_in   = '0;
                        open_in   = '0;
                        active_in = 1'b0;
                     end else begin
                        base_in  = link_ff - AW'(4);
                        state_in = S_POPRD;
                     end
                  end
                  csfa_pkg::FUNC_ALLOC: begin
                     if (!active_ff || (open_ff == '0)) begin
                        status_in = csfa_pkg::STATUS_EMPTY;
                     end else if (alloc_full) begin
                        status_in = csfa_pkg::STATUS_NO_SPACE;
                     end else begin
                        offset_in = csfa_pkg::ADDR_W'(end_ff);
                        end_in    = AW'(W'(end_ff) + W'(req_len));
                     end
                  end
                  csfa_pkg::FUNC_WRITE: begin
                     mem_wen = 1'b1;
                  end
                  csfa_pkg::FUNC_READ: begin
                     mem_ren  = 1'b1;
                     state_in = S_RDWAIT;
                  end
                  default: begin
                     status_in = csfa_pkg::STATUS_EMPTY;
                  end
               endcase
            end
         end
         S_PUSH: begin
            mem_wen = 1'b1;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff[3:0] == 4'd15) begin
               link_in   = base_ff + AW'(4);
               end_in    = base_ff + AW'(csfa_pkg::HDR_BYTES);
               open_in   = open_ff + csfa_pkg::FRAME_W'(1);
               active_in = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_POPRD: begin
            mem_ren = !cnt_ff[4];
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff != 5'd0) begin
               hdr_in = {mem_rdata, hdr_ff[HDR_W-1:csfa_pkg::BYTE_W]};
            end
            if (cnt_ff[4]) begin
               state_in = S_POPCHK;
            end
         end
         S_POPCHK: begin
            state_in = S_DONE;
            if (canary_bad) begin
               status_in = csfa_pkg::STATUS_CORRUPT;
            end else begin
               end_in  = base_ff;
               link_in = saved_link[AW-1:0];
               open_in = open_ff - csfa_pkg::FRAME_W'(1);
            end
         end
         S_RDWAIT: begin
            rbyte_in = mem_rdata;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         end_ff    <= '0;
         link_ff   <= '0;
         open_ff   <= '0;
         active_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         end_ff    <= end_in;
         link_ff   <= link_in;
         open_ff   <= open_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      hdr_ff    <= hdr_in;
      status_ff <= status_in;
      offset_ff <= offset_in;
      rbyte_ff  <= rbyte_in;
   end

endmodule

`default_nettype wire
